@@ src/tal_pkg.sv @@
// Shared types and constants of the thick anti-aliased line rasterizer.
package tal_pkg;

  localparam int PixelLevel = 1;
  localparam int MaxHalf    = 2048;
  localparam int SpanLen    = 2 * PixelLevel + 1;
  localparam int LevW       = $clog2(2 * PixelLevel + 2);
  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int DivSteps   = 35;
  localparam int SqrtBits   = 18;

  localparam logic [11:0] HalfReset = 12'd512;
  localparam logic [1:0]  RegHalfWidth  = 2'd0;
  localparam logic [1:0]  RegHalfHeight = 2'd1;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [12:0] sx;
    logic signed [12:0] sy;
    logic signed [12:0] ex;
    logic signed [12:0] ey;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } item_t;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_MA   = 14'b00000000000010,
    S_MB   = 14'b00000000000100,
    S_MC   = 14'b00000000001000,
    S_MD   = 14'b00000000010000,
    S_DIV  = 14'b00000000100000,
    S_SQRT = 14'b00000001000000,
    S_SPAN = 14'b00000010000000,
    S_PA   = 14'b00000100000000,
    S_PX   = 14'b00001000000000,
    S_PY   = 14'b00010000000000,
    S_PS   = 14'b00100000000000,
    S_PN   = 14'b01000000000000,
    S_PW   = 14'b10000000000000
  } state_e;

endpackage

@@ src/tal_front.sv @@
// Front end: accepts request words, classifies them and queues them for the back end.
module tal_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [12:0] start_x_i,
  input  logic signed [12:0] start_y_i,
  input  logic signed [12:0] end_x_i,
  input  logic signed [12:0] end_y_i,
  input  logic [7:0]         color_red_i,
  input  logic [7:0]         color_green_i,
  input  logic [7:0]         color_blue_i,
  output logic               q_valid_o,
  output tal_pkg::item_t     q_item_o,
  input  logic               q_pop_i
);

  tal_pkg::item_t               entries_q [tal_pkg::QDepth];
  logic [tal_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [tal_pkg::QPtrW:0]      count_q;
  tal_pkg::item_t               item_in;
  logic                         push;

  always_comb begin
    item_in.op    = req_type_i ? tal_pkg::OP_STEP : tal_pkg::OP_START;
    item_in.sx    = start_x_i;
    item_in.sy    = start_y_i;
    item_in.ex    = end_x_i;
    item_in.ey    = end_y_i;
    item_in.red   = color_red_i;
    item_in.green = color_green_i;
    item_in.blue  = color_blue_i;
  end

  assign in_stall_o = (count_q == (tal_pkg::QPtrW+1)'(tal_pkg::QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (q_pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (tal_pkg::QPtrW+1)'(push) - (tal_pkg::QPtrW+1)'(q_pop_i);
    end
  end

endmodule

@@ src/tal_back.sv @@
// Back end: segment setup, norm reciprocal, midpoint walk and per-pixel shading.
module tal_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  tal_pkg::item_t     q_item_i,
  output logic               q_pop_o,
  input  logic [11:0]        half_width_i,
  input  logic [11:0]        half_height_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [11:0]        pix_col_o,
  output logic [11:0]        pix_row_o,
  output logic [7:0]         pix_red_o,
  output logic [7:0]         pix_green_o,
  output logic [7:0]         pix_blue_o,
  output logic               in_window_o,
  output logic               last_of_step_o,
  output logic               line_done_o
);

  tal_pkg::state_e state_q, state_d;

  // segment state
  logic signed [13:0] cur_x_q, cur_y_q, end_major_q;
  logic signed [16:0] dec_q, inc_s_q, inc_d_q;
  logic               mirr_q, steep_q, fin_q, done_q;
  logic signed [13:0] a_q, b_q;
  logic signed [12:0] sx_q, sy_q;
  logic signed [29:0] c_q;
  logic [27:0]        n2_q;
  logic [17:0]        inv_q;
  logic [7:0]         red_q, green_q, blue_q;

  // reciprocal unit
  logic [27:0]        rem_q;
  logic [34:0]        quo_q;
  logic [5:0]         cnt_q;
  logic [17:0]        root_q;

  // pixel datapath
  logic [tal_pkg::LevW-1:0] lev_q;
  logic signed [13:0] px_q, py_q;
  logic               inw_q;
  logic signed [30:0] acc_q;
  logic [17:0]        mag_q;
  logic               big_q;
  logic [12:0]        w_q;

  logic               out_valid_q;
  logic [11:0]        col_q, row_q;
  logic [7:0]         ored_q, ogreen_q, oblue_q;
  logic               oinw_q, olast_q, odone_q;

  // shared 14x14 multiplier
  logic signed [13:0] mul_x, mul_y;
  logic signed [27:0] prod;

  always_comb begin
    mul_x = a_q;
    mul_y = a_q;
    unique case (state_q)
      tal_pkg::S_MB: begin mul_x = b_q; mul_y = b_q; end
      tal_pkg::S_MC: begin mul_x = 14'(sx_q); mul_y = a_q; end
      tal_pkg::S_MD: begin mul_x = 14'(sy_q); mul_y = b_q; end
      tal_pkg::S_PX: begin mul_x = a_q; mul_y = px_q; end
      tal_pkg::S_PY: begin mul_x = b_q; mul_y = py_q; end
      default: begin mul_x = a_q; mul_y = a_q; end
    endcase
  end
  assign prod = mul_x * mul_y;

  // start setup from the queue head
  logic signed [12:0] o_sx, o_sy, o_ex, o_ey;
  logic signed [13:0] dxs, dx, dy;
  logic               st_steep;
  always_comb begin
    if (q_item_i.sy > q_item_i.ey) begin
      o_sx = q_item_i.ex; o_sy = q_item_i.ey; o_ex = q_item_i.sx; o_ey = q_item_i.sy;
    end else begin
      o_sx = q_item_i.sx; o_sy = q_item_i.sy; o_ex = q_item_i.ex; o_ey = q_item_i.ey;
    end
    dxs = 14'(o_ex) - 14'(o_sx);
    dx  = dxs[13] ? -dxs : dxs;
    dy  = 14'(o_ey) - 14'(o_sy);
    st_steep = dy > dx;
  end

  // walk step
  logic               diag;
  logic signed [13:0] dir;
  assign diag = dec_q > 0;
  assign dir  = mirr_q ? -14'sd1 : 14'sd1;

  // reciprocal helpers
  logic [28:0] rem_sh;
  logic        qbit;
  logic [17:0] trial;
  logic [35:0] trial_sq;
  assign rem_sh   = {rem_q, (cnt_q == 6'(tal_pkg::DivSteps - 1))};
  assign qbit     = rem_sh >= {1'b0, n2_q};
  assign trial    = root_q | (18'd1 << cnt_q[4:0]);
  assign trial_sq = trial * trial;

  // pixel helpers
  logic signed [13:0] lev_s, nx, ny;
  logic signed [14:0] xs, ys, hw, hh;
  logic               win;
  logic signed [31:0] s_sum;
  logic [31:0]        s_mag;
  logic [35:0]        dq_prod;
  logic [29:0]        dq;
  logic [20:0]        r_mul, g_mul, b_mul;
  logic               out_free, last_pix;

  always_comb begin
    lev_s = 14'(lev_q) - 14'(tal_pkg::PixelLevel);
    nx = cur_x_q;
    ny = cur_y_q;
    if (steep_q) nx = mirr_q ? cur_x_q - lev_s : cur_x_q + lev_s;
    else ny = cur_y_q + lev_s;
    xs = 15'(nx);
    ys = 15'(ny);
    hw = $signed({3'b000, half_width_i});
    hh = $signed({3'b000, half_height_i});
    win = (xs + hw >= 0) && (xs < hw) && (ys + hh >= 0) && (ys < hh);
    s_sum = (32'(acc_q) <<< 1) + 32'(a_q) + 32'(b_q);
    s_mag = s_sum[31] ? 32'(-s_sum) : 32'(s_sum);
    dq_prod = mag_q * inv_q;
    dq = dq_prod[35:6];
    r_mul = red_q * w_q;
    g_mul = green_q * w_q;
    b_mul = blue_q * w_q;
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign last_pix = (lev_q == tal_pkg::LevW'(tal_pkg::SpanLen - 1));
  assign q_pop_o  = (state_q == tal_pkg::S_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tal_pkg::S_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.op == tal_pkg::OP_START) state_d = tal_pkg::S_MA;
          else if (!fin_q) state_d = tal_pkg::S_SPAN;
        end
      end
      tal_pkg::S_MA: state_d = tal_pkg::S_MB;
      tal_pkg::S_MB: state_d = tal_pkg::S_MC;
      tal_pkg::S_MC: state_d = tal_pkg::S_MD;
      tal_pkg::S_MD: state_d = (n2_q == '0) ? tal_pkg::S_SPAN : tal_pkg::S_DIV;
      tal_pkg::S_DIV: if (cnt_q == '0) state_d = tal_pkg::S_SQRT;
      tal_pkg::S_SQRT: if (cnt_q == '0) state_d = tal_pkg::S_SPAN;
      tal_pkg::S_SPAN: state_d = tal_pkg::S_PA;
      tal_pkg::S_PA: state_d = tal_pkg::S_PX;
      tal_pkg::S_PX: state_d = tal_pkg::S_PY;
      tal_pkg::S_PY: state_d = tal_pkg::S_PS;
      tal_pkg::S_PS: state_d = tal_pkg::S_PN;
      tal_pkg::S_PN: state_d = tal_pkg::S_PW;
      tal_pkg::S_PW: if (out_free) state_d = last_pix ? tal_pkg::S_IDLE : tal_pkg::S_PA;
      default: state_d = tal_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tal_pkg::S_IDLE;
      fin_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tal_pkg::S_IDLE && q_valid_i && q_item_i.op == tal_pkg::OP_START) begin
        fin_q <= 1'b0;
      end
      if (state_q == tal_pkg::S_SPAN &&
          (steep_q ? cur_y_q : cur_x_q) == end_major_q) begin
        fin_q <= 1'b1;
      end
      if (state_q == tal_pkg::S_PW && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0; cur_y_q <= '0; end_major_q <= '0;
      dec_q <= '0; inc_s_q <= '0; inc_d_q <= '0;
      mirr_q <= 1'b0; steep_q <= 1'b0;
      a_q <= '0; b_q <= '0; c_q <= '0; inv_q <= '0;
      red_q <= '0; green_q <= '0; blue_q <= '0;
    end else begin
      unique case (state_q)
        tal_pkg::S_IDLE: begin
          if (q_valid_i && q_item_i.op == tal_pkg::OP_START) begin
            steep_q <= st_steep;
            mirr_q  <= o_sx > o_ex;
            a_q     <= dy;
            b_q     <= 14'(o_sx) - 14'(o_ex);
            cur_x_q <= 14'(o_sx);
            cur_y_q <= 14'(o_sy);
            red_q   <= q_item_i.red;
            green_q <= q_item_i.green;
            blue_q  <= q_item_i.blue;
            inv_q   <= '0;
            if (st_steep) begin
              dec_q       <= 17'(dx) * 17'sd2 - 17'(dy);
              inc_s_q     <= 17'(dx) * 17'sd2;
              inc_d_q     <= (17'(dx) - 17'(dy)) * 17'sd2;
              end_major_q <= 14'(o_ey);
            end else begin
              dec_q       <= 17'(dy) * 17'sd2 - 17'(dx);
              inc_s_q     <= 17'(dy) * 17'sd2;
              inc_d_q     <= (17'(dy) - 17'(dx)) * 17'sd2;
              end_major_q <= 14'(o_ex);
            end
          end else if (q_valid_i && !fin_q) begin
            dec_q <= dec_q + (diag ? inc_d_q : inc_s_q);
            if (steep_q) begin
              cur_y_q <= cur_y_q + 14'sd1;
              if (diag) cur_x_q <= cur_x_q + dir;
            end else begin
              cur_x_q <= cur_x_q + dir;
              if (diag) cur_y_q <= cur_y_q + 14'sd1;
            end
          end
        end
        tal_pkg::S_MD: c_q <= -(30'(acc_q) + 30'(prod));
        tal_pkg::S_SQRT: begin
          if (cnt_q == '0) inv_q <= (trial_sq <= {1'b0, quo_q}) ? trial : root_q;
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tal_pkg::S_IDLE: begin
        sx_q <= o_sx;
        sy_q <= o_sy;
      end
      tal_pkg::S_MA: acc_q <= 31'(prod);
      tal_pkg::S_MB: n2_q  <= 28'(acc_q + 31'(prod));
      tal_pkg::S_MC: begin
        acc_q <= 31'(prod);
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= 6'(tal_pkg::DivSteps - 1);
      end
      tal_pkg::S_DIV: begin
        rem_q <= qbit ? 28'(rem_sh - {1'b0, n2_q}) : rem_sh[27:0];
        quo_q <= {quo_q[33:0], qbit};
        if (cnt_q == '0) begin
          cnt_q  <= 6'(tal_pkg::SqrtBits - 1);
          root_q <= '0;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
      tal_pkg::S_SQRT: begin
        if (trial_sq <= {1'b0, quo_q}) root_q <= trial;
        cnt_q <= cnt_q - 6'd1;
      end
      tal_pkg::S_SPAN: begin
        done_q <= (steep_q ? cur_y_q : cur_x_q) == end_major_q;
        lev_q  <= '0;
      end
      tal_pkg::S_PA: begin
        px_q  <= nx;
        py_q  <= ny;
        inw_q <= win;
      end
      tal_pkg::S_PX: acc_q <= 31'(prod);
      tal_pkg::S_PY: acc_q <= acc_q + 31'(prod) + 31'(c_q);
      tal_pkg::S_PS: begin
        mag_q <= s_mag[17:0];
        big_q <= |s_mag[31:18];
      end
      tal_pkg::S_PN: begin
        // a large distance with a nonzero reciprocal always clamps the weight
        if (big_q && inv_q != '0) w_q <= '0;
        else w_q <= (dq < 30'd4096) ? 13'(30'd4096 - dq) : 13'd0;
      end
      tal_pkg::S_PW: begin
        if (out_free) begin
          col_q    <= inw_q ? 12'(px_q + 14'(half_width_i)) : 12'd0;
          row_q    <= inw_q ? 12'(py_q + 14'(half_height_i)) : 12'd0;
          ored_q   <= inw_q ? r_mul[19:12] : 8'd0;
          ogreen_q <= inw_q ? g_mul[19:12] : 8'd0;
          oblue_q  <= inw_q ? b_mul[19:12] : 8'd0;
          oinw_q   <= inw_q;
          olast_q  <= last_pix;
          odone_q  <= done_q;
          lev_q    <= lev_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign pix_col_o      = col_q;
  assign pix_row_o      = row_q;
  assign pix_red_o      = ored_q;
  assign pix_green_o    = ogreen_q;
  assign pix_blue_o     = oblue_q;
  assign in_window_o    = oinw_q;
  assign last_of_step_o = olast_q;
  assign line_done_o    = odone_q;

endmodule

@@ src/thick_antialiased_line_raster_top.sv @@
// Top level of the thick anti-aliased line rasterizer.
// Words enter a two-entry queue and are carried out one at a time by the back end,
// which emits 3 pixel words per span (2L+1 with L = 1), each pixel passing states
// PA, PX, PY, PS, PN and PW through a shared 14x14 multiplier, a reciprocal multiply
// and the color scalers; a pixel waits in PW while the output stalls. A start word
// first passes setup states MA to MD, a restoring division and a bitwise square
// root for the norm reciprocal (division and root are skipped when both endpoints
// coincide).
module thick_antialiased_line_raster_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [12:0] start_x_i,
  input  logic signed [12:0] start_y_i,
  input  logic signed [12:0] end_x_i,
  input  logic signed [12:0] end_y_i,
  input  logic [7:0]         color_red_i,
  input  logic [7:0]         color_green_i,
  input  logic [7:0]         color_blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [11:0]        pix_col_o,
  output logic [11:0]        pix_row_o,
  output logic [7:0]         pix_red_o,
  output logic [7:0]         pix_green_o,
  output logic [7:0]         pix_blue_o,
  output logic               in_window_o,
  output logic               last_of_step_o,
  output logic               line_done_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [11:0]        cfg_data_i
);

  logic [11:0]    half_width_q, half_height_q, cfg_sat;
  logic           q_valid, q_pop;
  tal_pkg::item_t q_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_sat = (cfg_data_i > 12'(tal_pkg::MaxHalf)) ? 12'(tal_pkg::MaxHalf) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q  <= tal_pkg::HalfReset;
      half_height_q <= tal_pkg::HalfReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == tal_pkg::RegHalfWidth) half_width_q <= cfg_sat;
      if (cfg_index_i == tal_pkg::RegHalfHeight) half_height_q <= cfg_sat;
    end
  end

  tal_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i,
    .start_x_i, .start_y_i, .end_x_i, .end_y_i,
    .color_red_i, .color_green_i, .color_blue_i,
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  tal_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .half_width_i  (half_width_q),
    .half_height_i (half_height_q),
    .out_valid_o, .out_stall_i, .pix_col_o, .pix_row_o,
    .pix_red_o, .pix_green_o, .pix_blue_o,
    .in_window_o, .last_of_step_o, .line_done_o
  );

  a_half_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_width_q <= 12'(tal_pkg::MaxHalf) && half_height_q <= 12'(tal_pkg::MaxHalf))
    else $error("window register above limit");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_window_o |-> pix_col_o == '0 && pix_row_o == '0 &&
      pix_red_o == '0 && pix_green_o == '0 && pix_blue_o == '0)
    else $error("pixel outside window carries data");

  a_inside_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_window_o |->
      {1'b0, pix_col_o} < {half_width_q, 1'b0} && {1'b0, pix_row_o} < {half_height_q, 1'b0})
    else $error("pixel inside window out of buffer range");

endmodule
